>>> design/sme_pkg.sv
// Package for the stable matching engine: sizes, codes, FSM state type,
// and the command/status structs between controller and datapath.
// No dependencies.
package sme_pkg;

  localparam int MAX_AGENTS = 16;
  localparam int AGENT_W    = $clog2(MAX_AGENTS);
  localparam int PART_W     = AGENT_W + 1;
  localparam int RAM_DEPTH  = MAX_AGENTS * MAX_AGENTS;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);

  localparam logic [PART_W-1:0] NO_PARTNER = PART_W'(MAX_AGENTS);

  typedef enum logic [1:0] {
    FUNC_LOAD_PROP = 2'd0,
    FUNC_LOAD_ACC  = 2'd1,
    FUNC_RUN       = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_DEQ,
    S_PREF,
    S_RANK1,
    S_RANK2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_pref;
    logic load_rank;
    logic init;
    logic deq;
    logic pref;
    logic rank1;
    logic rank2;
    logic out_adv;
  } cmd_t;

  typedef struct packed {
    logic exhausted;
    logic w_bad;
    logic held_free;
    logic queue_empty;
    logic out_last;
  } stat_t;

endpackage

>>> design/sme_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sme_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/sme_ctrl.sv
// Controller state machine of the stable matching engine.
// Depends on sme_pkg for the state type, codes and command/status structs.
module sme_ctrl
  import sme_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       in_ready,
  output logic       out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_func == FUNC_RUN)) state_nxt = S_INIT;
      end
      S_INIT:  state_nxt = S_DEQ;
      S_DEQ: begin
        state_nxt = stat.exhausted ? S_OUT : S_PREF;
      end
      S_PREF: begin
        priority if (stat.w_bad) begin
          state_nxt = S_DEQ;
        end else if (stat.held_free) begin
          state_nxt = stat.queue_empty ? S_OUT : S_DEQ;
        end else begin
          state_nxt = S_RANK1;
        end
      end
      S_RANK1: state_nxt = S_RANK2;
      S_RANK2: state_nxt = S_DEQ;
      S_OUT: begin
        if (out_ready && stat.out_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_pref = in_valid && (in_func == FUNC_LOAD_PROP);
        cmd.load_rank = in_valid && (in_func == FUNC_LOAD_ACC);
      end
      S_INIT:  cmd.init  = 1'b1;
      S_DEQ:   cmd.deq   = 1'b1;
      S_PREF:  cmd.pref  = 1'b1;
      S_RANK1: cmd.rank1 = 1'b1;
      S_RANK2: cmd.rank2 = 1'b1;
      S_OUT: begin
        out_valid   = 1'b1;
        cmd.out_adv = out_ready;
      end
      default: ;
    endcase
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while results are pending");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && stat.out_last |=> in_ready)
    else $error("engine not idle after final result transfer");

  a_out_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_DEQ || $past(state_r) == S_PREF))
    else $error("results started without a finished run");

endmodule

>>> design/sme_dp.sv
// Datapath of the stable matching engine: preference RAMs, matching arrays,
// free-proposer queue and result index. Depends on sme_pkg and sme_ram.
module sme_dp
  import sme_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic [AGENT_W-1:0] in_person,
  input  logic [AGENT_W-1:0] in_position,
  input  logic [AGENT_W-1:0] in_choice,
  output stat_t              stat,
  output logic [AGENT_W-1:0] out_proposer,
  output logic [PART_W-1:0]  out_partner
);

  logic [4:0]         active_count_r;
  logic [PART_W-1:0]  n;

  logic [PART_W-1:0]  holder_r  [MAX_AGENTS];
  logic [PART_W-1:0]  partner_r [MAX_AGENTS];
  logic [PART_W-1:0]  nc_r      [MAX_AGENTS];
  logic [AGENT_W-1:0] queue_r   [MAX_AGENTS];
  logic [AGENT_W-1:0] head_r;
  logic [PART_W-1:0]  count_r;
  logic [AGENT_W-1:0] out_idx_r;

  logic [AGENT_W-1:0] m_r, w_r, held_r, rank_m_r;

  logic [AGENT_W-1:0] m_cur, tail, pref_rdata, rank_rdata;
  logic [PART_W-1:0]  nc_cur, held_cur;
  logic [RAM_AW-1:0]  pref_raddr, rank_raddr;

  // Clamp the active count to 1..MAX_AGENTS.
  always_comb begin
    priority if (active_count_r == '0) begin
      n = PART_W'(1);
    end else if (active_count_r > 5'(MAX_AGENTS)) begin
      n = PART_W'(MAX_AGENTS);
    end else begin
      n = PART_W'(active_count_r);
    end
  end

  assign m_cur      = queue_r[head_r];
  assign nc_cur     = nc_r[m_cur];
  assign tail       = head_r + count_r[AGENT_W-1:0];
  assign held_cur   = holder_r[pref_rdata];
  assign pref_raddr = {m_cur, nc_cur[AGENT_W-1:0]};
  assign rank_raddr = cmd.pref ? {pref_rdata, m_r} : {w_r, held_r};

  always_comb begin
    stat.exhausted   = nc_cur >= n;
    stat.w_bad       = {1'b0, pref_rdata} >= n;
    stat.held_free   = held_cur == NO_PARTNER;
    stat.queue_empty = count_r == '0;
    stat.out_last    = {1'b0, out_idx_r} == (n - PART_W'(1));
  end

  sme_ram #(.WIDTH(AGENT_W), .DEPTH(RAM_DEPTH)) u_pref_ram (
    .clk   (clk),
    .we    (cmd.load_pref),
    .waddr ({in_person, in_position}),
    .wdata (in_choice),
    .raddr (pref_raddr),
    .rdata (pref_rdata)
  );

  // An acceptor entry is stored as the rank of the named proposer.
  sme_ram #(.WIDTH(AGENT_W), .DEPTH(RAM_DEPTH)) u_rank_ram (
    .clk   (clk),
    .we    (cmd.load_rank),
    .waddr ({in_person, in_choice}),
    .wdata (in_position),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= 5'(MAX_AGENTS);
      head_r         <= '0;
      count_r        <= '0;
      out_idx_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        active_count_r <= cfg_wr_data;
      end
      priority if (cmd.init) begin
        head_r    <= '0;
        count_r   <= n;
        out_idx_r <= '0;
      end else if (cmd.deq) begin
        head_r  <= head_r + AGENT_W'(1);
        count_r <= count_r - PART_W'(1);
      end else if ((cmd.pref && stat.w_bad) || cmd.rank2) begin
        count_r <= count_r + PART_W'(1);
      end else if (cmd.out_adv) begin
        out_idx_r <= out_idx_r + AGENT_W'(1);
      end else begin
        head_r <= head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < MAX_AGENTS; i++) begin
        holder_r[i]  <= NO_PARTNER;
        partner_r[i] <= NO_PARTNER;
        nc_r[i]      <= '0;
        queue_r[i]   <= AGENT_W'(i);
      end
    end
    if (cmd.deq) begin
      m_r <= m_cur;
      if (stat.exhausted) begin
        partner_r[m_cur] <= NO_PARTNER;
      end else begin
        nc_r[m_cur] <= nc_cur + PART_W'(1);
      end
    end
    if (cmd.pref) begin
      w_r    <= pref_rdata;
      held_r <= held_cur[AGENT_W-1:0];
      if (stat.w_bad) begin
        queue_r[tail] <= m_r;
      end else if (stat.held_free) begin
        holder_r[pref_rdata] <= {1'b0, m_r};
        partner_r[m_r]       <= {1'b0, pref_rdata};
      end
    end
    if (cmd.rank1) begin
      rank_m_r <= rank_rdata;
    end
    if (cmd.rank2) begin
      // Strictly better rank wins; on a tie the acceptor keeps her holder.
      if (rank_m_r < rank_rdata) begin
        holder_r[w_r]     <= {1'b0, m_r};
        partner_r[m_r]    <= {1'b0, w_r};
        partner_r[held_r] <= NO_PARTNER;
        queue_r[tail]     <= held_r;
      end else begin
        queue_r[tail] <= m_r;
      end
    end
  end

  assign out_proposer = out_idx_r;
  assign out_partner  = partner_r[out_idx_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= PART_W'(MAX_AGENTS))
    else $error("free queue overflow");

  a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq |-> count_r != '0)
    else $error("dequeue from empty free queue");

  a_rank_holder: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rank2 |-> holder_r[w_r] == {1'b0, held_r})
    else $error("rank compare against a proposer the acceptor does not hold");

endmodule

>>> design/stable_matching_engine.sv
// Top level of the stable matching engine.
// Depends on sme_pkg, sme_ctrl and sme_dp (which uses sme_ram).

// This block computes a proposer-side stable matching between the first n
// proposers and the first n acceptors, where n is the active count written
// through the configuration port (0 counts as 1, values above 16 as 16).
// Items with func load proposer preferences (person, position, choice) or
// acceptor preferences, where the acceptor entry is kept as the rank of the
// named proposer. A run item starts the matching: a setup state, then each
// proposal passes the dequeue and preference states, and also both rank
// states when the acceptor is already held, because both ranks come in turn
// from the single read port of the rank memory. Then n results are
// transferred, one per cycle when the consumer is ready, in proposer order,
// with last set on the final one. If a proposer runs out of list entries
// the run stops early; he reports unmatched (partner 16) and the others
// report what they held at that moment. No new item is taken while a run
// or its result transfers are in progress. Preference entries that were
// never written must not be read by a run.
module stable_matching_engine
  import sme_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [AGENT_W-1:0] in_person,
  input  logic [AGENT_W-1:0] in_position,
  input  logic [AGENT_W-1:0] in_choice,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [AGENT_W-1:0] out_proposer,
  output logic [PART_W-1:0]  out_partner,
  output logic               out_last
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences loads, setup, proposals and result transfers.
  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // The datapath holds the preference memories and all matching state.
  sme_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_person    (in_person),
    .in_position  (in_position),
    .in_choice    (in_choice),
    .stat         (stat),
    .out_proposer (out_proposer),
    .out_partner  (out_partner)
  );

  assign out_last = stat.out_last;

endmodule

>>> test/sme_checker.sv
// Checker for the stable matching engine: follows the config port and both channels,
// predicts the result transfers of every run and compares them with the block's output.
// Depends on sme_pkg for sizes, func codes and the no-partner value.
`timescale 1ns / 100ps

module sme_checker
  import sme_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [AGENT_W-1:0] in_person,
  input  logic [AGENT_W-1:0] in_position,
  input  logic [AGENT_W-1:0] in_choice,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [AGENT_W-1:0] out_proposer,
  input  logic [PART_W-1:0]  out_partner,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);

  typedef struct packed {
    logic [AGENT_W-1:0] proposer;
    logic [PART_W-1:0]  partner;
    logic               last;
  } match_rec_t;

  match_rec_t         match_queue[$];
  logic [AGENT_W-1:0] pref_mem[RAM_DEPTH];
  logic [AGENT_W-1:0] rank_mem[RAM_DEPTH];
  logic [4:0]         count_reg;

  task automatic log_mismatch(input string text);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", text);
  endtask

  // Proposer-side deferred acceptance over the first n agents of each side.
  task automatic predict_matching();
    int                n;
    int                head;
    int                cnt;
    int                m;
    int                w;
    int                held;
    bit                done;
    logic [PART_W-1:0] holder[MAX_AGENTS];
    logic [PART_W-1:0] partner[MAX_AGENTS];
    int                next_idx[MAX_AGENTS];
    int                fifo[MAX_AGENTS];
    match_rec_t        rec;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > MAX_AGENTS) n = MAX_AGENTS;
    for (int i = 0; i < MAX_AGENTS; i++) begin
      holder[i]   = NO_PARTNER;
      partner[i]  = NO_PARTNER;
      next_idx[i] = 0;
      fifo[i]     = i;
    end
    head = 0;
    cnt  = n;
    done = 1'b0;
    while (cnt > 0 && !done) begin
      m    = fifo[head];
      head = (head + 1) % MAX_AGENTS;
      cnt--;
      if (next_idx[m] >= n) begin
        // His list ran out: the whole run stops here.
        partner[m] = NO_PARTNER;
        done = 1'b1;
      end else begin
        w = pref_mem[m * MAX_AGENTS + next_idx[m]];
        next_idx[m]++;
        if (w >= n) begin
          fifo[(head + cnt) % MAX_AGENTS] = m;
          cnt++;
        end else if (holder[w] == NO_PARTNER) begin
          holder[w]  = PART_W'(m);
          partner[m] = PART_W'(w);
        end else begin
          held = holder[w];
          if (rank_mem[w * MAX_AGENTS + m] < rank_mem[w * MAX_AGENTS + held]) begin
            holder[w]     = PART_W'(m);
            partner[m]    = PART_W'(w);
            partner[held] = NO_PARTNER;
            fifo[(head + cnt) % MAX_AGENTS] = held;
          end else begin
            fifo[(head + cnt) % MAX_AGENTS] = m;
          end
          cnt++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      rec.proposer = AGENT_W'(i);
      rec.partner  = partner[i];
      rec.last     = (i == n - 1);
      match_queue.push_back(rec);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      count_reg = 5'd16;
      match_queue.delete();
      for (int i = 0; i < RAM_DEPTH; i++) begin
        pref_mem[i] = '0;
        rank_mem[i] = '0;
      end
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (match_queue.size() == 0) begin
          log_mismatch($sformatf("unexpected result proposer %0d partner %0d last %0d",
                                 out_proposer, out_partner, out_last));
        end else begin
          if (out_proposer !== match_queue[0].proposer ||
              out_partner !== match_queue[0].partner ||
              out_last !== match_queue[0].last) begin
            log_mismatch($sformatf({"expected proposer %0d partner %0d last %0d, ",
                                    "got proposer %0d partner %0d last %0d"},
                                   match_queue[0].proposer, match_queue[0].partner,
                                   match_queue[0].last, out_proposer, out_partner,
                                   out_last));
          end
          void'(match_queue.pop_front());
        end
      end
      if (cfg_wr_en) count_reg = cfg_wr_data;
      if (in_valid && in_ready) begin
        case (in_func)
          FUNC_LOAD_PROP: pref_mem[{in_person, in_position}] = in_choice;
          FUNC_LOAD_ACC:  rank_mem[{in_person, in_choice}] = in_position;
          FUNC_RUN:       predict_matching();
          default: ;
        endcase
      end
    end
    pending = match_queue.size();
  end

endmodule

>>> test/stable_matching_engine_tb.sv
// Testbench top for the stable matching engine: drives reset, config writes and
// preference/run transfers, and gives the verdict. Depends on sme_pkg, the block
// and sme_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module stable_matching_engine_tb;
  import sme_pkg::*;

  // Func code 3 is not decoded by the block; items carrying it must be dropped.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // The limit leaves a wide margin over a full 16-agent run.
  localparam int CYCLE_LIMIT = 400000;
  // This many idle cycles make sure the block is quiet.
  localparam int SETTLE_CYCLES = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [4:0]         cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = '0;
  logic [AGENT_W-1:0] in_person = '0;
  logic [AGENT_W-1:0] in_position = '0;
  logic [AGENT_W-1:0] in_choice = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [AGENT_W-1:0] out_proposer;
  logic [PART_W-1:0]  out_partner;
  logic               out_last;

  int fail_count;
  int pending;
  int results_seen;
  int cycle_count = 0;
  int items_sent = 0;
  int runs = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Which preference entries hold written data. A run may only read written entries,
  // so start_run first fills any hole in the active n-by-n block.
  bit pref_ok[RAM_DEPTH];
  bit rank_ok[RAM_DEPTH];
  bit big_loaded = 1'b0;
  int order[MAX_AGENTS];

  // Active counts per idling phase; 0 checks the clamping at the low end.
  int count_plan[3][3] = '{'{3, 0, 2}, '{4, 1, 1}, '{2, 0, 1}};

  stable_matching_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_person    (in_person),
    .in_position  (in_position),
    .in_choice    (in_choice),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_proposer (out_proposer),
    .out_partner  (out_partner),
    .out_last     (out_last)
  );

  sme_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_person    (in_person),
    .in_position  (in_position),
    .in_choice    (in_choice),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_proposer (out_proposer),
    .out_partner  (out_partner),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at random, changing only on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake or a run that never finishes ends the test here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One input transfer. Called at a falling edge and returns at a falling edge, so
  // back-to-back items keep valid high without lowering it in between.
  task automatic send_item(input logic [1:0] f, input logic [AGENT_W-1:0] p,
                           input logic [AGENT_W-1:0] pos, input logic [AGENT_W-1:0] c);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_person   <= p;
    in_position <= pos;
    in_choice   <= c;
    // Ready is read right after the edge, before the block's own updates land.
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_pref(input int p, input int pos, input int c);
    send_item(FUNC_LOAD_PROP, AGENT_W'(p), AGENT_W'(pos), AGENT_W'(c));
    pref_ok[p * MAX_AGENTS + pos] = 1'b1;
  endtask

  // The acceptor entry carries the rank in the position field and the proposer in choice.
  task automatic load_rank(input int w, input int m, input int r);
    send_item(FUNC_LOAD_ACC, AGENT_W'(w), AGENT_W'(r), AGENT_W'(m));
    rank_ok[w * MAX_AGENTS + m] = 1'b1;
  endtask

  // Hold the sender back until every expected result has been transferred, then let
  // the block settle. Config writes are only made after this.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_count(input logic [4:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic shuffle_order(input int n);
    int j;
    int t;
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
  endtask

  // A well-formed instance: every list of the active block is a permutation, so the
  // run goes all the way to a complete matching.
  task automatic load_instance(input int n);
    for (int p = 0; p < n; p++) begin
      shuffle_order(n);
      for (int pos = 0; pos < n; pos++) load_pref(p, pos, order[pos]);
    end
    for (int w = 0; w < n; w++) begin
      shuffle_order(n);
      for (int m = 0; m < n; m++) load_rank(w, m, order[m]);
    end
  endtask

  // Small edits on top of the stored instance: duplicates and inactive acceptors in a
  // list (rejections, exhausted lists), equal ranks, dropped func codes and loads
  // anywhere in the memories.
  task automatic perturb(input int n);
    int k;
    k = $urandom_range(0, 3);
    repeat (k) begin
      case ($urandom_range(0, 3))
        0: load_pref($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                     $urandom_range(0, 15));
        1: load_rank($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                     $urandom_range(0, n - 1));
        2: send_item(FUNC_UNUSED, AGENT_W'($urandom_range(0, 15)),
                     AGENT_W'($urandom_range(0, 15)), AGENT_W'($urandom_range(0, 15)));
        default: begin
          if ($urandom_range(0, 1))
            load_pref($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
          else
            load_rank($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
        end
      endcase
    end
  endtask

  task automatic start_run(input int n);
    for (int p = 0; p < n; p++) begin
      for (int pos = 0; pos < n; pos++) begin
        if (!pref_ok[p * MAX_AGENTS + pos]) load_pref(p, pos, $urandom_range(0, n - 1));
        if (!rank_ok[p * MAX_AGENTS + pos]) load_rank(p, pos, $urandom_range(0, n - 1));
      end
    end
    // The other fields of a run item mean nothing, so they carry random bits.
    send_item(FUNC_RUN, AGENT_W'($urandom_range(0, 15)), AGENT_W'($urandom_range(0, 15)),
              AGENT_W'($urandom_range(0, 15)));
    runs++;
  endtask

  initial begin
    int n;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 49;

    // Directed part. A count of zero acts as one: a single pair matched.
    set_count(5'd0);
    load_pref(0, 0, 0);
    load_rank(0, 0, 0);
    start_run(1);
    // An unused func code with every field at its top value is dropped.
    send_item(FUNC_UNUSED, 4'd15, 4'd15, 4'd15);
    // The only proposer names an inactive acceptor, is rejected and then runs out
    // of list, so he reports unmatched.
    load_pref(0, 0, 15);
    start_run(1);
    // Two proposers both want acceptor 0, who prefers proposer 1 and drops proposer 0.
    set_count(5'd2);
    load_pref(0, 0, 0);
    load_pref(0, 1, 1);
    load_pref(1, 0, 0);
    load_pref(1, 1, 1);
    load_rank(0, 0, 1);
    load_rank(0, 1, 0);
    load_rank(1, 0, 0);
    load_rank(1, 1, 1);
    start_run(2);
    // Equal ranks at acceptor 0: she keeps the proposer she already holds.
    load_rank(0, 1, 1);
    start_run(2);
    // A count above the maximum acts as sixteen. Each proposer names a distinct
    // acceptor first, so every proposal is taken at once and only these entries
    // are read.
    set_count(5'd31);
    for (int p = 0; p < MAX_AGENTS; p++) load_pref(p, 0, p);
    send_item(FUNC_RUN, 4'd0, 4'd0, 4'd0);
    runs++;

    // Random part, one idling pattern per phase and several counts in each.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 15; recv_idle_pct = 49; end
        1: begin send_idle_pct = 49; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 3; s++) begin
        set_count(5'(count_plan[ph][s]));
        n = count_plan[ph][s];
        if (n < 1) n = 1;
        if (n > MAX_AGENTS) n = MAX_AGENTS;
        for (int r = 0; r < 3; r++) begin
          // Full reloads stay cheap at small counts; the largest count gets one.
          if ((r == 0 && (n < 8 || !big_loaded)) || (n <= 4 && $urandom_range(0, 3) == 0)) begin
            load_instance(n);
            if (n == MAX_AGENTS) big_loaded = 1'b1;
          end else begin
            perturb(n);
          end
          start_run(n);
        end
      end
    end

    drain();
    repeat (50) @(negedge clk);
    $display("Covered %0d input transfers and %0d matching runs, %0d results checked, %0d bad.",
             items_sent, runs, results_seen, fail_count);
    $display("Active counts 0 to 31, ties, rejections, exhausted lists and dropped func codes.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
